@@ rtl/faq_pkg.sv @@
// ----------------------------------------------------------------------------
// faq_pkg
// Types, codes and constants shared by the fault alert qualifier modules.
// ----------------------------------------------------------------------------
package faq_pkg;

    localparam int TGT_W      = 3;
    localparam int HEALTH_W   = 2;
    localparam int LAT_W      = 16;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int KIND_W     = 2;
    localparam int DOWN_W     = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 64;

    // downtime in seconds: ms * RECIP_MS >> RECIP_SHIFT, exact for any 32-bit ms
    localparam int          RECIP_W     = 29;
    localparam int          RECIP_SHIFT = 38;
    localparam logic [28:0] RECIP_MS    = 29'd274877907;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [HEALTH_W-1:0] {
        H_UNKNOWN = 2'd0,
        H_UP      = 2'd1,
        H_DOWN    = 2'd2,
        H_OTHER   = 2'd3
    } health_t;

    typedef enum logic [KIND_W-1:0] {
        K_NONE     = 2'd0,
        K_ALERT    = 2'd1,
        K_RECOVERY = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 2'd0,
        CFG_THRESHOLD  = 2'd1,
        CFG_ALERT_CD   = 2'd2,
        CFG_RECOVER_CD = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_THR,
        S_ELAPSED,
        S_COOL,
        S_DOWN,
        S_SCALE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] failures;
        logic [TIME_W-1:0]  alert_stamp;
        logic               raised;
        logic [TIME_W-1:0]  outage_start;
        logic [TIME_W-1:0]  alert_outage_start;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [TGT_W-1:0]  wr_sel;
        entry_t            wr_entry;
    } tbl_wr_t;

endpackage

@@ rtl/fault_alert_qualifier.sv @@
// ----------------------------------------------------------------------------
// fault_alert_qualifier
// Qualifies per-target health reports into down alerts and recovery notices.
// ----------------------------------------------------------------------------
// One report at a time: a new beat is taken only in S_IDLE, after the previous
// result is loaded (which waits on m_tready); the shared subtractor is used in
// four successive steps, followed by one registered multiply for the seconds value.
// Reset (aresetn low, synchronous): table entries cleared, registers to their
// defaults (disabled, threshold 3, cooldowns 300000 ms and 60000 ms).
// ----------------------------------------------------------------------------
module fault_alert_qualifier #(
    parameter int NUM_TARGETS = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // target_index[2:0], health[4:3], latency_ms[20:5], now_ms[52:21]
    input  logic [faq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // event_target[2:0], downtime_s[25:3], event_latency_ms[41:26],
    // fail_count[57:42], any_alert_active[58]
    output logic [faq_pkg::M_TDATA_W-1:0]  m_tdata,
    // event_kind[1:0]
    output logic [faq_pkg::KIND_W-1:0]     m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [faq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [faq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import faq_pkg::*;

    // configuration
    logic               enable_reg;
    logic [COUNT_W-1:0] thr_reg;
    logic [TIME_W-1:0]  alert_cd_reg;
    logic [TIME_W-1:0]  rec_cd_reg;

    // report being worked on
    logic [TGT_W-1:0]   tgt_reg;
    health_t            health_reg;
    logic [LAT_W-1:0]   lat_reg;
    logic [TIME_W-1:0]  now_reg;

    // working values
    logic [COUNT_W-1:0] fnew_reg,   fnew_next;
    logic [TIME_W-1:0]  os_new_reg, os_new_next;
    logic [TIME_W-1:0]  aos_new_reg, aos_new_next;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [TIME_W-1:0]  diff_reg;
    logic               thr_ge_reg;
    logic               cool_ge_reg;
    kind_t              kind_reg, kind_next;

    // result
    logic [M_TDATA_W-1:0] m_tdata_reg;
    kind_t                m_tuser_reg;
    logic                 m_tvalid_reg;

    state_t state_reg, state_next;

    entry_t                 rd_entry;
    tbl_wr_t                tbl_wr;
    logic [NUM_TARGETS-1:0] raised_vec;
    logic [NUM_TARGETS-1:0] raised_after;

    logic [TIME_W-1:0] alu_a, alu_b, alu_diff;
    logic              alu_ge;
    logic [DOWN_W-1:0] span_s;

    logic              in_beat, out_load;
    logic              tgt_valid, active, is_down, is_up, la_zero;
    logic              alert_ok, rec_ok;
    logic [DOWN_W-1:0] down_s;
    logic [COUNT_W-1:0] count_out;
    logic              any_active;

    faq_table #(.NUM_TARGETS(NUM_TARGETS)) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_sel     (tgt_reg),
        .rd_entry   (rd_entry),
        .wr         (tbl_wr),
        .raised_vec (raised_vec)
    );

    faq_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    faq_scale u_scale (
        .aclk    (aclk),
        .span_ms (diff_reg),
        .span_s  (span_s)
    );

    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign tgt_valid = 32'(tgt_reg) < NUM_TARGETS;
    assign active    = tgt_valid && enable_reg;
    assign is_down   = (health_reg == H_DOWN);
    assign is_up     = (health_reg == H_UP);
    assign la_zero   = (rd_entry.alert_stamp == '0);

    // decision, valid in S_DOWN once both compares are registered
    assign alert_ok = active && is_down && thr_ge_reg && (la_zero || cool_ge_reg);
    assign rec_ok   = active && is_up && rd_entry.raised &&
                      (rd_entry.alert_outage_start != '0) && !la_zero &&
                      ((rec_cd_reg == '0) || cool_ge_reg);

    always_comb begin
        fnew_next = rd_entry.failures;
        if (active && is_down && (rd_entry.failures != COUNT_MAX)) begin
            fnew_next = rd_entry.failures + COUNT_W'(1);
        end
        os_new_next = rd_entry.outage_start;
        if (active && is_down && (fnew_next == COUNT_W'(1))) begin
            os_new_next = now_reg;
        end
    end

    always_comb begin
        aos_new_next = rd_entry.alert_outage_start;
        if (alert_ok && (rd_entry.alert_outage_start == '0)) begin
            aos_new_next = (os_new_reg != '0) ? os_new_reg : now_reg;
        end
        if (alert_ok) begin
            kind_next = K_ALERT;
        end else if (rec_ok) begin
            kind_next = K_RECOVERY;
        end else begin
            kind_next = K_NONE;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_THR;
            S_THR:     state_next = S_ELAPSED;
            S_ELAPSED: state_next = S_COOL;
            S_COOL:    state_next = S_DOWN;
            S_DOWN:    state_next = S_SCALE;
            S_SCALE:   state_next = S_DONE;
            S_DONE:    if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        alu_a    = '0;
        alu_b    = '0;
        unique case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_THR: begin
                alu_a = {{(TIME_W-COUNT_W){1'b0}}, fnew_next};
                alu_b = {{(TIME_W-COUNT_W){1'b0}}, thr_reg};
            end
            S_ELAPSED: begin
                alu_a = now_reg;
                alu_b = rd_entry.alert_stamp;
            end
            S_COOL: begin
                alu_a = elapsed_reg;
                alu_b = is_down ? alert_cd_reg : rec_cd_reg;
            end
            S_DOWN: begin
                alu_a = now_reg;
                alu_b = aos_new_next;
            end
            S_SCALE: ;
            S_DONE:  out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // table update on the cycle the result is loaded
    always_comb begin
        tbl_wr.wr_en    = out_load && active;
        tbl_wr.wr_sel   = tgt_reg;
        tbl_wr.wr_entry = rd_entry;
        case (kind_reg)
            K_RECOVERY: begin
                tbl_wr.wr_entry = '0;
                tbl_wr.wr_entry.alert_stamp = now_reg;
            end
            K_ALERT: begin
                tbl_wr.wr_entry.failures           = fnew_reg;
                tbl_wr.wr_entry.alert_stamp        = now_reg;
                tbl_wr.wr_entry.raised             = 1'b1;
                tbl_wr.wr_entry.outage_start       = os_new_reg;
                tbl_wr.wr_entry.alert_outage_start = aos_new_reg;
            end
            default: begin
                tbl_wr.wr_entry.failures     = fnew_reg;
                tbl_wr.wr_entry.outage_start = os_new_reg;
            end
        endcase
    end

    always_comb begin
        raised_after = raised_vec;
        for (int i = 0; i < NUM_TARGETS; i++) begin
            if (tbl_wr.wr_en && (TGT_W'(i) == tgt_reg)) begin
                raised_after[i] = tbl_wr.wr_entry.raised;
            end
        end
    end

    assign any_active = enable_reg && (|raised_after);
    assign count_out  = tgt_valid ? tbl_wr.wr_entry.failures : '0;
    assign down_s     = ((kind_reg != K_NONE) && (aos_new_reg != '0)) ? span_s : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            enable_reg   <= 1'b0;
            thr_reg      <= COUNT_W'(3);
            alert_cd_reg <= TIME_W'(300000);
            rec_cd_reg   <= TIME_W'(60000);
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_ENABLE:     enable_reg   <= cfg_data[0];
                    CFG_THRESHOLD:  thr_reg      <= cfg_data[COUNT_W-1:0];
                    CFG_ALERT_CD:   alert_cd_reg <= cfg_data[TIME_W-1:0];
                    CFG_RECOVER_CD: rec_cd_reg   <= cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            tgt_reg    <= s_tdata[2:0];
            health_reg <= health_t'(s_tdata[4:3]);
            lat_reg    <= s_tdata[20:5];
            now_reg    <= s_tdata[52:21];
        end
        case (state_reg)
            S_THR: begin
                fnew_reg   <= fnew_next;
                os_new_reg <= os_new_next;
                thr_ge_reg <= alu_ge;
            end
            S_ELAPSED: elapsed_reg <= alu_diff;
            S_COOL:    cool_ge_reg <= alu_ge;
            S_DOWN: begin
                diff_reg    <= alu_diff;
                aos_new_reg <= aos_new_next;
                kind_reg    <= kind_next;
            end
            default: ;
        endcase
        if (out_load) begin
            m_tuser_reg <= kind_reg;
            m_tdata_reg <= {5'b0, any_active, count_out, lat_reg, down_s, tgt_reg};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

@@ rtl/faq_alu.sv @@
// ----------------------------------------------------------------------------
// faq_alu
// Shared 32-bit subtractor: wrapping difference and unsigned greater-or-equal.
// ----------------------------------------------------------------------------
module faq_alu (
    input  logic [faq_pkg::TIME_W-1:0] op_a,
    input  logic [faq_pkg::TIME_W-1:0] op_b,
    output logic [faq_pkg::TIME_W-1:0] diff,
    output logic                       ge
);
    import faq_pkg::*;

    logic [TIME_W:0] wide;

    assign wide = {1'b0, op_a} - {1'b0, op_b};
    assign diff = wide[TIME_W-1:0];
    // no borrow out means a >= b
    assign ge   = ~wide[TIME_W];

endmodule

@@ rtl/faq_scale.sv @@
// ----------------------------------------------------------------------------
// faq_scale
// Registered conversion of a millisecond span into whole seconds.
// ----------------------------------------------------------------------------
module faq_scale (
    input  logic                       aclk,
    input  logic [faq_pkg::TIME_W-1:0] span_ms,
    output logic [faq_pkg::DOWN_W-1:0] span_s
);
    import faq_pkg::*;

    logic [TIME_W+RECIP_W-1:0] prod;
    logic [DOWN_W-1:0]         span_s_reg;

    assign prod = {{RECIP_W{1'b0}}, span_ms} * {{TIME_W{1'b0}}, RECIP_MS};

    always_ff @(posedge aclk) begin
        span_s_reg <= prod[RECIP_SHIFT+DOWN_W-1:RECIP_SHIFT];
    end

    assign span_s = span_s_reg;

endmodule

@@ rtl/faq_table.sv @@
// ----------------------------------------------------------------------------
// faq_table
// Per-target state entries with one read selector and one write port.
// ----------------------------------------------------------------------------
module faq_table #(
    parameter int NUM_TARGETS = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [faq_pkg::TGT_W-1:0] rd_sel,
    output faq_pkg::entry_t           rd_entry,
    input  faq_pkg::tbl_wr_t          wr,
    output logic [NUM_TARGETS-1:0]    raised_vec
);
    import faq_pkg::*;

    entry_t entry_reg [NUM_TARGETS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TARGETS; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (wr.wr_en) begin
            for (int i = 0; i < NUM_TARGETS; i++) begin
                if (TGT_W'(i) == wr.wr_sel) begin
                    entry_reg[i] <= wr.wr_entry;
                end
            end
        end
    end

    always_comb begin
        rd_entry = '0;
        for (int i = 0; i < NUM_TARGETS; i++) begin
            if (TGT_W'(i) == rd_sel) begin
                rd_entry = entry_reg[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_TARGETS; i++) begin
            raised_vec[i] = entry_reg[i].raised;
        end
    end

endmodule
